@@ hdl/ang_pkg.sv @@
// Package: shared types, widths and constants of the audio noise gate.
`timescale 1ns / 1ps

package ang_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 25;   // Q24 envelope and gain, up to just below 2.0
    localparam int COEF_W   = 17;   // Q16 smoothing coefficient
    localparam int FRAC_W   = 16;   // fraction bits of a coefficient
    localparam int GAIN_FRAC_W = 24;
    localparam int LEVEL_SHIFT = 9;

    localparam int MUL_A_W = STATE_W + 1;              // signed difference
    localparam int MUL_B_W = COEF_W + 1;               // coefficient, zero-extended
    localparam int PROD_W  = MUL_A_W + MUL_B_W;        // 44
    localparam int SUM_W   = PROD_W - FRAC_W;          // 28
    localparam int SCALED_W = SAMPLE_W + 1;            // |sample * gain| >> 24

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [STATE_W-1:0] Q24_ONE   = STATE_W'(1 << GAIN_FRAC_W);
    localparam logic [STATE_W-1:0] STATE_MAX = '1;

    localparam logic [STATE_W-1:0] THRESHOLD_RST = STATE_W'(335544);
    localparam logic [COEF_W-1:0]  ATTACK_RST    = COEF_W'(22938);
    localparam logic [COEF_W-1:0]  RELEASE_RST   = COEF_W'(1311);

    localparam logic [SCALED_W-1:0] POS_LIMIT = SCALED_W'(32767);
    localparam logic [SCALED_W-1:0] NEG_LIMIT = SCALED_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE   = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_end_out;
    } out_item_t;

    // Operand pair presented to the shared multiplier
    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_op_t;

endpackage

@@ hdl/audio_noise_gate.sv @@
// Top level: noise gate with envelope follower, APB register port and sequencer.
`timescale 1ns / 1ps
// Gate enabled, an accepted sample passes the envelope multiply and add, the gain
//   multiply and add, the output multiply and finish, then the write state, where the
//   result is registered; gate disabled, it goes straight to the write state. One
//   sample is in flight at a time, and the three multiplies share one multiplier.
// The output register lets the next sample start while a result waits to be taken.
// Reset (rst_n low, asynchronous) clears envelope, gain and the sequencer, and loads
//   the register defaults: gate off, threshold 0.02, attack 0.35, release 0.02.

module audio_noise_gate
    import ang_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // sample input channel
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  in_item_t              sample_data,

    // gated output channel
    output logic                  gated_valid,
    input  logic                  gated_stall,
    output out_item_t             gated_data,

    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // One step of the sequencer per state; each multiply state is followed by a
    // state that consumes the registered product.
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_ENV_MUL  = 8'b0000_0010,
        ST_ENV_ADD  = 8'b0000_0100,
        ST_GAIN_MUL = 8'b0000_1000,
        ST_GAIN_ADD = 8'b0001_0000,
        ST_OUT_MUL  = 8'b0010_0000,
        ST_OUT_FIN  = 8'b0100_0000,
        ST_WRITE    = 8'b1000_0000
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;

    logic                       gate_enable_reg, gate_enable_next;
    logic [STATE_W-1:0]         gate_threshold_reg, gate_threshold_next;
    logic [COEF_W-1:0]          attack_coeff_reg, attack_coeff_next;
    logic [COEF_W-1:0]          release_coeff_reg, release_coeff_next;

    logic [STATE_W-1:0]         envelope_reg, envelope_next;
    logic [STATE_W-1:0]         gain_reg, gain_next;

    // per-sample working registers (payload, no reset)
    logic [SAMPLE_W-1:0]        mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic                       blk_reg, blk_next;
    logic signed [SAMPLE_W-1:0] result_reg, result_next;

    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                       cfg_wr;
    logic [REG_IDX_W-1:0]       cfg_index;
    logic                       in_accept;
    logic                       out_accept;

    mul_op_t                    mul_op;
    logic signed [PROD_W-1:0]   prod;

    logic [SAMPLE_W:0]          sample_ext;
    logic [STATE_W-1:0]         level;
    logic [STATE_W-1:0]         gain_target;
    logic [SCALED_W-1:0]        scaled;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign cfg_index  = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign in_accept  = sample_valid & ~sample_stall;
    assign out_accept = out_valid_reg & ~gated_stall;

    // Busy from acceptance until the result is parked in the output register
    assign sample_stall = (state_reg != ST_IDLE);

    assign sample_ext  = {sample_data.sample_in[SAMPLE_W-1], sample_data.sample_in};
    assign level       = {mag_reg, LEVEL_SHIFT'(0)};
    assign gain_target = (envelope_reg > gate_threshold_reg) ? Q24_ONE : '0;
    // |sample| * gain is below 2^40, so the top product bits above this slice are zero
    assign scaled      = prod[GAIN_FRAC_W +: SCALED_W];

    // Add the floored Q16 step to the current value and clamp to the state range.
    function automatic logic [STATE_W-1:0] step_sat(
        input logic [STATE_W-1:0]       cur,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SUM_W-1:0] sum;
        sum = signed'({(SUM_W - STATE_W)'(0), cur}) + signed'(p[PROD_W-1:FRAC_W]);
        if (sum[SUM_W-1])
            step_sat = '0;
        else if (sum[SUM_W-2:STATE_W] != '0)
            step_sat = STATE_MAX;
        else
            step_sat = sum[STATE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    ang_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    // ------------------------------------------------------------------
    // Sequencer and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        gate_enable_next    = gate_enable_reg;
        gate_threshold_next = gate_threshold_reg;
        attack_coeff_next   = attack_coeff_reg;
        release_coeff_next  = release_coeff_reg;
        envelope_next       = envelope_reg;
        gain_next           = gain_reg;
        mag_next            = mag_reg;
        neg_next            = neg_reg;
        blk_next            = blk_reg;
        result_next         = result_reg;
        out_data_next       = out_data_reg;
        out_valid_next      = out_valid_reg;
        mul_op              = '0;

        // drop the held result once the consumer takes it
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next    = sample_data.sample_in[SAMPLE_W-1];
                    mag_next    = sample_ext[SAMPLE_W] ? SAMPLE_W'((SAMPLE_W + 1)'(0) - sample_ext)
                                                       : sample_ext[SAMPLE_W-1:0];
                    blk_next    = sample_data.block_end;
                    result_next = sample_data.sample_in;   // pass-through value
                    state_next  = gate_enable_reg ? ST_ENV_MUL : ST_WRITE;
                end
            end

            ST_ENV_MUL:
            begin
                mul_op.a   = signed'({1'b0, level}) - signed'({1'b0, envelope_reg});
                mul_op.b   = signed'({1'b0, (level > envelope_reg) ? attack_coeff_reg
                                                                   : release_coeff_reg});
                state_next = ST_ENV_ADD;
            end

            ST_ENV_ADD:
            begin
                envelope_next = step_sat(envelope_reg, prod);
                state_next    = ST_GAIN_MUL;
            end

            ST_GAIN_MUL:
            begin
                mul_op.a   = signed'({1'b0, gain_target}) - signed'({1'b0, gain_reg});
                mul_op.b   = signed'({1'b0, (gain_target > gain_reg) ? attack_coeff_reg
                                                                     : release_coeff_reg});
                state_next = ST_GAIN_ADD;
            end

            ST_GAIN_ADD:
            begin
                gain_next  = step_sat(gain_reg, prod);
                state_next = ST_OUT_MUL;
            end

            ST_OUT_MUL:
            begin
                mul_op.a   = signed'({1'b0, gain_reg});
                mul_op.b   = signed'({(MUL_B_W - SAMPLE_W)'(0), mag_reg});
                state_next = ST_OUT_FIN;
            end

            ST_OUT_FIN:
            begin
                // truncate toward zero: scale the magnitude, then restore the sign
                if (neg_reg)
                    result_next = (scaled > NEG_LIMIT) ? SAMPLE_MIN
                                                       : SAMPLE_W'(SCALED_W'(0) - scaled);
                else
                    result_next = (scaled > POS_LIMIT) ? SAMPLE_MAX
                                                       : signed'(scaled[SAMPLE_W-1:0]);
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !gated_stall)
                begin
                    out_data_next.sample_out    = result_reg;
                    out_data_next.block_end_out = blk_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes; any write of the enable register restarts the follower
        if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_ENABLE:
                begin
                    gate_enable_next = pwdata[0];
                    envelope_next    = '0;
                    gain_next        = '0;
                end
                REG_THRESHOLD: gate_threshold_next = pwdata[STATE_W-1:0];
                REG_ATTACK:    attack_coeff_next   = pwdata[COEF_W-1:0];
                REG_RELEASE:   release_coeff_next  = pwdata[COEF_W-1:0];
                default:       gate_enable_next    = gate_enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_ENABLE:    prdata = {(APB_DATA_W - 1)'(0), gate_enable_reg};
            REG_THRESHOLD: prdata = {(APB_DATA_W - STATE_W)'(0), gate_threshold_reg};
            REG_ATTACK:    prdata = {(APB_DATA_W - COEF_W)'(0), attack_coeff_reg};
            REG_RELEASE:   prdata = {(APB_DATA_W - COEF_W)'(0), release_coeff_reg};
            default:       prdata = '0;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            gate_enable_reg    <= 1'b0;
            gate_threshold_reg <= THRESHOLD_RST;
            attack_coeff_reg   <= ATTACK_RST;
            release_coeff_reg  <= RELEASE_RST;
            envelope_reg       <= '0;
            gain_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            gate_enable_reg    <= gate_enable_next;
            gate_threshold_reg <= gate_threshold_next;
            attack_coeff_reg   <= attack_coeff_next;
            release_coeff_reg  <= release_coeff_next;
            envelope_reg       <= envelope_next;
            gain_reg           <= gain_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        blk_reg      <= blk_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign gated_valid = out_valid_reg;
    assign gated_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_enabled_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && gate_enable_reg |=> state_reg == ST_ENV_MUL)
        else $error("enabled sample did not start the envelope update");

    a_idle_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && !cfg_wr |=> $stable(envelope_reg) && $stable(gain_reg))
        else $error("envelope or gain changed while idle");

    a_write_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE && out_valid_reg && gated_stall |=> state_reg == ST_WRITE)
        else $error("result left the sequencer while the output register was full");

endmodule

@@ hdl/ang_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module ang_mul
    import ang_pkg::*;
(
    input  logic                     clk,
    input  mul_op_t                  op,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op.a * op.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ sim/gate_output_checker.sv @@
// Checker: predicts gated samples from the observed channels and compares them.
`timescale 1ns / 1ps

module gate_output_checker
    import ang_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_stall,
    input  in_item_t              sample_data,
    input  logic                  gated_valid,
    input  logic                  gated_stall,
    input  out_item_t             gated_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    pending,
    output int                    checked,
    output int                    open_seen
);

    logic                 gate_on;
    logic [STATE_W-1:0]   threshold;
    logic [COEF_W-1:0]    atk_coef;
    logic [COEF_W-1:0]    rel_coef;
    logic [STATE_W-1:0]   envelope;
    logic [STATE_W-1:0]   gain;
    out_item_t            gated_expected_q[$];
    int                   err_n;
    int                   checked_n;
    int                   open_n;

    // Move cur toward target by a Q16 step, floor-shifted, clamped to the state range
    function automatic logic [STATE_W-1:0] smooth_toward(input logic [STATE_W-1:0] cur,
                                                         input logic [STATE_W-1:0] target,
                                                         input logic [COEF_W-1:0] coef);
        longint nxt;
        nxt = longint'(cur) + (((longint'(target) - longint'(cur)) * longint'(coef)) >>> FRAC_W);
        if (nxt < 0)
            nxt = 0;
        if (nxt > longint'(STATE_MAX))
            nxt = longint'(STATE_MAX);
        return STATE_W'(nxt);
    endfunction

    // Advance envelope and gain by one sample and return the gated result
    function automatic out_item_t gate_sample(input in_item_t item);
        out_item_t          res;
        int                 s;
        longint             mag;
        longint             scaled;
        logic [STATE_W-1:0] level;
        logic [STATE_W-1:0] target;
        s = int'(item.sample_in);
        res.sample_out = item.sample_in;
        res.block_end_out = item.block_end;
        if (gate_on)
        begin
            mag = (s < 0) ? -s : s;
            level = STATE_W'(mag << LEVEL_SHIFT);
            envelope = smooth_toward(envelope, level, (level > envelope) ? atk_coef : rel_coef);
            target = (envelope > threshold) ? Q24_ONE : '0;
            gain = smooth_toward(gain, target, (target > gain) ? atk_coef : rel_coef);
            scaled = (mag * longint'(gain)) >>> GAIN_FRAC_W;
            if (s < 0)
                scaled = -scaled;
            if (scaled > 32767)
                scaled = 32767;
            if (scaled < -32768)
                scaled = -32768;
            res.sample_out = SAMPLE_W'(scaled);
            if (gain != '0)
                open_n++;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            gate_on   = 1'b0;
            threshold = THRESHOLD_RST;
            atk_coef  = ATTACK_RST;
            rel_coef  = RELEASE_RST;
            envelope  = '0;
            gain      = '0;
            gated_expected_q.delete();
            err_n     = 0;
            checked_n = 0;
            open_n    = 0;
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
            open_seen  <= 0;
        end
        else
        begin
            // compare the result first, so a new sample in the same cycle cannot match it
            if (gated_valid && !gated_stall)
            begin
                if (gated_expected_q.size() == 0)
                begin
                    err_n++;
                    if (err_n <= 10)
                        $display("gated transaction with nothing expected: sample %0d end %0b",
                                 gated_data.sample_out, gated_data.block_end_out);
                end
                else
                begin
                    want = gated_expected_q.pop_front();
                    checked_n++;
                    if (gated_data.sample_out !== want.sample_out ||
                        gated_data.block_end_out !== want.block_end_out)
                    begin
                        err_n++;
                        if (err_n <= 10)
                            $display("gated mismatch: expected sample %0d end %0b, got sample %0d end %0b",
                                     want.sample_out, want.block_end_out,
                                     gated_data.sample_out, gated_data.block_end_out);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[REG_IDX_W+1:2])
                    REG_ENABLE:
                    begin
                        gate_on  = pwdata[0];
                        envelope = '0;
                        gain     = '0;
                    end
                    REG_THRESHOLD: threshold = pwdata[STATE_W-1:0];
                    REG_ATTACK:    atk_coef  = pwdata[COEF_W-1:0];
                    REG_RELEASE:   rel_coef  = pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end

            if (sample_valid && !sample_stall)
                gated_expected_q.push_back(gate_sample(sample_data));

            mismatches <= err_n;
            pending    <= gated_expected_q.size();
            checked    <= checked_n;
            open_seen  <= open_n;
        end
    end

endmodule

@@ sim/audio_noise_gate_tb.sv @@
// Testbench top: drives samples and register writes into the noise gate and gives the verdict.
`timescale 1ns / 1ps

module audio_noise_gate_tb;
    import ang_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_LEN     = 400;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 170;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum int {SEG_SILENCE, SEG_TONE, SEG_DECAY, SEG_NOISE, SEG_EXTREME} seg_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    in_item_t              sample_data;
    logic                  gated_valid;
    logic                  gated_stall;
    out_item_t             gated_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int checked;
    int open_seen;

    int cycle_count = 0;
    int items_sent  = 0;
    int settings    = 0;
    int burst_left  = 1;
    int hold_req    = 0;
    int holds_done  = 0;

    audio_noise_gate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .gated_valid  (gated_valid),
        .gated_stall  (gated_stall),
        .gated_data   (gated_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // The checker watches every channel, including register writes, and keeps its own model
    gate_output_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .gated_valid  (gated_valid),
        .gated_stall  (gated_stall),
        .gated_data   (gated_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .open_seen    (open_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Guard against a hung handshake: stop the run with a failure once the limit is passed
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: stall on a random pattern, redrawn when its run ends. When a hold-off is
    // requested, keep stall high for a long stretch so the gate backs up and stalls its input.
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        gated_stall = 1'b0;
        mode = STALL_NONE;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != holds_done)
            begin
                gated_stall <= 1'b1;
                repeat (HOLD_LEN - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  gated_stall <= 1'b0;
                    STALL_LIGHT: gated_stall <= ($urandom_range(0, 99) < 25);
                    STALL_HEAVY: gated_stall <= ($urandom_range(0, 99) < 75);
                    default:     gated_stall <= ~gated_stall;
                endcase
            end
        end
    end

    // Offer one sample, hold it until the transaction completes, then maybe drop valid for a gap
    task automatic offer_sample(input int value, input bit last);
        in_item_t item;
        int       gap;
        item.sample_in = SAMPLE_W'(value);
        item.block_end = last;
        @(negedge clk);
        sample_valid <= 1'b1;
        sample_data  <= item;
        do
            @(posedge clk);
        while (sample_stall);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 20);
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 48);
        end
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Fill the bits above a register's width with random junk half of the time
    function automatic logic [APB_DATA_W-1:0] with_junk(input logic [APB_DATA_W-1:0] value,
                                                        input int width);
        logic [APB_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 1) != 0) ? $urandom() : '0;
        return value | (junk << width);
    endfunction

    // Coefficient choice, biased toward zero, unity and the top of the field
    function automatic logic [APB_DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 65536;
            2:       return 131071;
            5:       return $urandom_range(0, 131071);
            default: return $urandom_range(1, 65536);
        endcase
    endfunction

    initial
    begin
        seg_kind_t             kind;
        int                    seg_len;
        int                    amp;
        int                    s;
        int                    pick;
        int                    done;
        int                    start;
        bit                    en;
        logic [APB_DATA_W-1:0] thr;
        logic [REG_IDX_W-1:0]  r;

        // initialise every input of the block before reset
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_data  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Gate off after reset: samples must pass unchanged, extremes and both buffer marks
        offer_sample(32767, 1'b0);
        offer_sample(-32768, 1'b0);
        offer_sample(0, 1'b1);
        offer_sample(-1, 1'b0);
        offer_sample(1, 1'b1);
        drain_results();

        // Gate on with default coefficients: loud samples open it, silence starts the envelope's release
        reg_write(REG_ENABLE, 1);
        settings++;
        offer_sample(-32768, 1'b0);
        offer_sample(-32768, 1'b0);
        offer_sample(-32768, 1'b0);
        offer_sample(32767, 1'b0);
        offer_sample(32767, 1'b0);
        offer_sample(-1, 1'b0);
        offer_sample(1, 1'b0);
        offer_sample(0, 1'b0);
        offer_sample(0, 1'b0);
        offer_sample(0, 1'b1);
        drain_results();

        // Rewrite enable with the same value: envelope and gain must clear
        reg_write(REG_ENABLE, 1);
        offer_sample(20000, 1'b0);
        offer_sample(-20000, 1'b1);
        drain_results();

        // Coefficients near 2.0 and a zero threshold: overshoot, state saturation and a gain
        // above unity that must clip the output
        reg_write(REG_ATTACK, 131071);
        reg_write(REG_RELEASE, 131071);
        reg_write(REG_THRESHOLD, 0);
        settings++;
        offer_sample(-32768, 1'b0);
        offer_sample(32767, 1'b0);
        offer_sample(0, 1'b0);
        offer_sample(100, 1'b0);
        offer_sample(-32768, 1'b0);
        offer_sample(32767, 1'b1);
        drain_results();

        // All-ones threshold write must be trimmed to the register width; frozen attack
        reg_write(REG_THRESHOLD, 32'hFFFF_FFFF);
        reg_write(REG_ATTACK, 0);
        reg_write(REG_RELEASE, 65536);
        settings++;
        offer_sample(32767, 1'b0);
        offer_sample(-5, 1'b1);
        drain_results();

        // Random phases: new register settings, then audio-like segments
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            en = ($urandom_range(0, 99) < 85);
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = Q24_ONE;
                2:       thr = STATE_MAX;
                3:       thr = $urandom_range(0, 1 << 20);
                default: thr = $urandom_range(0, 1 << 24);
            endcase
            // write all four registers, rotating the order
            start = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
            begin
                r = REG_IDX_W'(start + k);
                case (r)
                    REG_ENABLE:    reg_write(REG_ENABLE, with_junk(APB_DATA_W'(en), 1));
                    REG_THRESHOLD: reg_write(REG_THRESHOLD, with_junk(thr, STATE_W));
                    REG_ATTACK:    reg_write(REG_ATTACK, with_junk(pick_coef(), COEF_W));
                    default:       reg_write(REG_RELEASE, with_junk(pick_coef(), COEF_W));
                endcase
            end
            settings++;

            // ask for a long receiver hold-off early in a few phases
            if (ph % 3 == 1)
                hold_req++;

            done = 0;
            while (done < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                kind = (pick < 3) ? SEG_SILENCE :
                       (pick < 6) ? SEG_TONE :
                       (pick < 7) ? SEG_DECAY :
                       (pick < 9) ? SEG_NOISE : SEG_EXTREME;
                seg_len = $urandom_range(4, 60);
                amp = $urandom_range(2048, 32767);
                for (int k = 0; k < seg_len && done < PHASE_ITEMS; k++)
                begin
                    case (kind)
                        SEG_SILENCE: s = $urandom_range(0, 127) - 64;
                        SEG_TONE:
                        begin
                            s = amp - $urandom_range(0, amp / 8);
                            if (k % 2 == 1)
                                s = -s;
                        end
                        SEG_DECAY:
                        begin
                            amp = amp * 7 / 8;
                            s = (k % 2 == 1) ? -amp : amp;
                        end
                        SEG_NOISE: s = int'($signed(16'($urandom())));
                        default:
                        begin
                            case ($urandom_range(0, 4))
                                0:       s = int'(SAMPLE_MAX);
                                1:       s = int'(SAMPLE_MIN);
                                2:       s = 0;
                                3:       s = -1;
                                default: s = 1;
                            endcase
                        end
                    endcase
                    // mark buffer ends at segment ends and now and then in between
                    offer_sample(s, (k == seg_len - 1) || ($urandom_range(0, 31) == 0));
                    done++;
                end
            end
            drain_results();
        end

        // let any stray result show up before the verdict
        repeat (20) @(negedge clk);

        $display("Run covered %0d samples over %0d register settings; %0d results checked, %0d with the gate open.",
                 items_sent, settings, checked, open_seen);
        $display("Receiver held off %0d times for %0d cycles to back the gate up.",
                 holds_done, HOLD_LEN);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
